>>> rtl/lgps_pkg.sv
// Shared types and constants of the LED group pattern sequencer.
package lgps_pkg;

  localparam int unsigned MAX_STEPS  = 16;
  localparam int unsigned MAX_LEDS   = 8;
  localparam int unsigned LANE_W     = 8;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned DUTY_W     = 64;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned ELAPSED_W  = 17;
  localparam int unsigned GROUP_W    = 4;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
  localparam logic [COUNT_W-1:0]   MAX_STEPS_C = COUNT_W'(MAX_STEPS);
  localparam logic [GROUP_W-1:0]   MAX_LEDS_C  = GROUP_W'(MAX_LEDS);

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_START = 2'd2,
    REQ_STOP  = 2'd3
  } req_type_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [SLOT_W-1:0]  step_slot;
    logic [DUR_W-1:0]   step_duration;
    logic [DUTY_W-1:0]  step_duties;
    logic [COUNT_W-1:0] step_count;
    logic               repeat_flag;
  } req_t;

  typedef struct packed {
    logic              running;
    logic [SLOT_W-1:0] step_index;
    logic [DUTY_W-1:0] duties;
    logic              start_ok;
    logic              finished;
  } rsp_t;

endpackage

>>> rtl/lgps_req_if.sv
// Request channel: valid/ready handshake with the request fields.
interface lgps_req_if;
  import lgps_pkg::*;

  logic               valid;
  logic               ready;
  req_type_e          req_type;
  logic [SLOT_W-1:0]  step_slot;
  logic [DUR_W-1:0]   step_duration;
  logic [DUTY_W-1:0]  step_duties;
  logic [COUNT_W-1:0] step_count;
  logic               repeat_flag;

  modport source (
    output valid, req_type, step_slot, step_duration, step_duties, step_count, repeat_flag,
    input  ready
  );
  modport sink (
    input  valid, req_type, step_slot, step_duration, step_duties, step_count, repeat_flag,
    output ready
  );
endinterface

>>> rtl/lgps_rsp_if.sv
// Result channel: valid/ready handshake with the result fields.
interface lgps_rsp_if;
  import lgps_pkg::*;

  logic              valid;
  logic              ready;
  logic              running;
  logic [SLOT_W-1:0] step_index;
  logic [DUTY_W-1:0] duties;
  logic              start_ok;
  logic              finished;

  modport source (
    output valid, running, step_index, duties, start_ok, finished,
    input  ready
  );
  modport sink (
    input  valid, running, step_index, duties, start_ok, finished,
    output ready
  );
endinterface

>>> rtl/lgps_in_stage.sv
// Input register: captures one request transaction per cycle while it is empty or its held request is taken.
module lgps_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  lgps_req_if.sink      req_i,
  input  logic          take_i,
  output logic          valid_o,
  output lgps_pkg::req_t req_o
);
  import lgps_pkg::*;

  logic valid_q, valid_d;
  req_t data_q;
  logic accept;

  assign req_i.ready = !valid_q || take_i;
  assign accept      = req_i.valid && req_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q.req_type      <= req_i.req_type;
      data_q.step_slot     <= req_i.step_slot;
      data_q.step_duration <= req_i.step_duration;
      data_q.step_duties   <= req_i.step_duties;
      data_q.step_count    <= req_i.step_count;
      data_q.repeat_flag   <= req_i.repeat_flag;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = data_q;
endmodule

>>> rtl/lgps_core.sv
// Sequencer state, step table and the single-pass update of one request.
module lgps_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lgps_pkg::GROUP_W-1:0] cfg_wdata_i,
  input  logic                        fire_i,
  input  lgps_pkg::req_t              req_i,
  output lgps_pkg::rsp_t              rsp_o
);
  import lgps_pkg::*;

  logic [DUR_W-1:0]  dur_tab  [MAX_STEPS];
  logic [DUTY_W-1:0] duty_tab [MAX_STEPS];

  logic [GROUP_W-1:0]   member_q;
  logic                 playing_q, playing_d;
  logic [SLOT_W-1:0]    step_q, step_d;
  logic [ELAPSED_W-1:0] elapsed_q, elapsed_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic                 repeat_q, repeat_d;

  logic [GROUP_W-1:0]   group;
  logic [DUTY_W-1:0]    lane_mask;
  logic [DUR_W-1:0]     cur_dur;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [COUNT_W-1:0]   next_step;
  logic                 start_bad;
  logic                 load;
  logic                 ok, fin;
  logic [DUTY_W-1:0]    word;

  assign group = (member_q > MAX_LEDS_C) ? MAX_LEDS_C : member_q;

  always_comb begin
    for (int i = 0; i < MAX_LEDS; i++) begin
      lane_mask[i*LANE_W +: LANE_W] = (GROUP_W'(i) < group) ? '1 : '0;
    end
  end

  assign cur_dur     = dur_tab[step_q];
  assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
  assign next_step   = {1'b0, step_q} + 1'b1;
  assign start_bad   = (req_i.step_count == '0) || (req_i.step_count > MAX_STEPS_C)
                       || (group == '0);
  assign load        = (req_i.req_type == REQ_LOAD);

  always_comb begin
    playing_d = playing_q;
    step_d    = step_q;
    elapsed_d = elapsed_q;
    count_d   = count_q;
    repeat_d  = repeat_q;
    ok        = 1'b0;
    fin       = 1'b0;
    unique case (req_i.req_type)
      REQ_TICK: begin
        if (playing_q && group != '0) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= {1'b0, cur_dur}) begin
            elapsed_d = '0;
            if (next_step >= count_q) begin
              step_d = '0;
              if (!repeat_q) begin
                playing_d = 1'b0;
                fin       = 1'b1;
              end
            end else begin
              step_d = next_step[SLOT_W-1:0];
            end
          end
        end
      end
      REQ_LOAD: begin
      end
      REQ_START: begin
        step_d    = '0;
        elapsed_d = '0;
        if (start_bad) begin
          playing_d = 1'b0;
        end else begin
          playing_d = 1'b1;
          count_d   = req_i.step_count;
          repeat_d  = req_i.repeat_flag;
          ok        = 1'b1;
        end
      end
      REQ_STOP: begin
        playing_d = 1'b0;
        step_d    = '0;
        elapsed_d = '0;
      end
      default: begin
      end
    endcase
  end

  // A load to the slot being shown is visible in the same result.
  assign word = (load && req_i.step_slot == step_d) ? req_i.step_duties : duty_tab[step_d];

  always_comb begin
    rsp_o.running    = playing_d;
    rsp_o.step_index = playing_d ? step_d : '0;
    rsp_o.duties     = playing_d ? (word & lane_mask) : '0;
    rsp_o.start_ok   = ok;
    rsp_o.finished   = fin;
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && load) begin
      dur_tab[req_i.step_slot]  <= req_i.step_duration;
      duty_tab[req_i.step_slot] <= req_i.step_duties;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      member_q  <= '0;
      playing_q <= 1'b0;
      step_q    <= '0;
      elapsed_q <= '0;
      count_q   <= '0;
      repeat_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        member_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        playing_q <= playing_d;
        step_q    <= step_d;
        elapsed_q <= elapsed_d;
        count_q   <= count_d;
        repeat_q  <= repeat_d;
      end
    end
  end
endmodule

>>> rtl/lgps_out_stage.sv
// Result register: holds one result transaction until the sink takes it.
module lgps_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  lgps_pkg::rsp_t rsp_i,
  output logic           free_o,
  lgps_rsp_if.source     rsp_o
);
  import lgps_pkg::*;

  logic valid_q, valid_d;
  rsp_t data_q;

  assign free_o = !valid_q || rsp_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= rsp_i;
    end
  end

  assign rsp_o.valid      = valid_q;
  assign rsp_o.running    = data_q.running;
  assign rsp_o.step_index = data_q.step_index;
  assign rsp_o.duties     = data_q.duties;
  assign rsp_o.start_ok   = data_q.start_ok;
  assign rsp_o.finished   = data_q.finished;
endmodule

>>> rtl/led_group_pattern_sequencer.sv
// Top level of the LED group pattern sequencer.
// Path: an accepted request is held in the input register, then passes the
//   combinational update into the result register.
// Throughput: one request per cycle while the result sink is ready; the result register frees as it is read,
//   so the input register and the update stage advance together in every such cycle.
// Reset: rst_ni clears the group size, play state, step, elapsed count, step count, repeat flag and valid bits.
//   The step table holds no reset value and must be loaded before it is played.
module led_group_pattern_sequencer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lgps_pkg::GROUP_W-1:0] cfg_wdata_i,
  lgps_req_if.sink                     req_i,
  lgps_rsp_if.source                   rsp_o
);
  import lgps_pkg::*;

  // Request held in the input register, waiting for the update stage.
  logic in_valid;
  req_t in_req;

  // Result computed from the held request and the current play state.
  rsp_t core_rsp;

  // The result register can take a new transaction this cycle.
  logic out_free;

  // Advance one request through the update stage: state and result register
  // both load on the same edge, so each request sees what the one before left.
  logic fire;
  assign fire = in_valid && out_free;

  lgps_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .take_i  (fire),
    .valid_o (in_valid),
    .req_o   (in_req)
  );

  // Hold the step table, group size and play state; compute the next state
  // and the result of the held request in one short combinational pass.
  lgps_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .req_i       (in_req),
    .rsp_o       (core_rsp)
  );

  // Drop the result into the output register; it holds under backpressure.
  lgps_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (fire),
    .rsp_i  (core_rsp),
    .free_o (out_free),
    .rsp_o  (rsp_o)
  );
endmodule
